### design/grr_pkg.sv
// Package for the group reverse reorder block.
// Holds sizes, payload types and the cell control struct; no dependencies.
package grr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int VALUE_W   = 32;
    localparam int SIZE_W    = 5;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;

    // Per-cycle command to every cell of the stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

### design/grr_if.sv
// Channel interfaces for the group reverse reorder block.
// Depends on grr_pkg for the payload types.
interface grr_in_if import grr_pkg::*;;
    logic   valid;
    logic   ready;
    t_value value;
    logic   end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface grr_out_if import grr_pkg::*;;
    logic   valid;
    logic   ready;
    t_value value_res;
    logic   group_last;
    logic   list_last;

    modport source (output valid, output value_res, output group_last,
                    output list_last, input ready);
    modport sink   (input valid, input value_res, input group_last,
                    input list_last, output ready);
endinterface

### design/grr_cell.sv
// One storage cell of the reversing stack.
// Depends on grr_pkg; loads from its left neighbor on push, right neighbor on pop.
module grr_cell
    import grr_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_value    i_from_left,
    input  t_value    i_from_right,
    output t_value    o_value
);

    t_value r_value;
    t_value n_value;

    // Shift toward the deep end on push, toward the top on pop
    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            n_value = i_from_left;
        end else if (i_ctl.pop) begin
            n_value = i_from_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### design/grr_stack.sv
// Row of MAX_GROUP cells forming a shift-register stack.
// Depends on grr_pkg and grr_cell; cell 0 is the top of the stack.
module grr_stack
    import grr_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_value    i_push_value,
    output t_value    o_top
);

    t_value w_cell [MAX_GROUP];

    genvar g;
    generate
        for (g = 0; g < MAX_GROUP; g++) begin : g_cell
            t_value w_left;
            t_value w_right;

            // Wire each cell to its neighbors; the ends take the input and zero
            if (g == 0) begin : g_first
                assign w_left = i_push_value;
            end else begin : g_mid_l
                assign w_left = w_cell[g-1];
            end
            if (g == MAX_GROUP - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[g+1];
            end

            grr_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_from_left  (w_left),
                .i_from_right (w_right),
                .o_value      (w_cell[g])
            );
        end
    endgenerate

    assign o_top = w_cell[0];

endmodule

### design/group_reverse_reorder_top.sv
// Group reverse reorder, top level.
// Depends on grr_pkg, grr_if, grr_stack and grr_cell.
//
// Usage: values enter on i_in (valid/ready, value + end_of_list) and are
// pushed onto a row of MAX_GROUP shift cells. When the buffered count
// reaches group_size, or a transaction carries end_of_list, the block
// stops taking input and pops the cells one per cycle onto o_out while the
// receiver takes them, so the group leaves in reverse order. group_last
// marks the last value of each group, list_last the last value of the list.
// After the transaction that closes the group, the state register enters
// drain and each pop loads the output register. No new input is taken
// until the whole group has been popped; i_in reopens in the cycle after
// the last pop, while the output register may still hold that value.
// When the receiver stalls, the output register holds and popping stops.
// Reset clears the fill count, the output valid and sets group_size to 1;
// cell contents are not cleared. group_size is written through
// i_cfg_we/i_cfg_data; the user must do so only while idle, as the block
// does not enforce it. 0 acts as 1, values above MAX_GROUP act as
// MAX_GROUP.
module group_reverse_reorder_top
    import grr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    grr_in_if.sink            i_in,
    grr_out_if.source         o_out
);

    t_state    r_state,  n_state;
    t_count    r_count,  n_count;
    t_count    r_size,   n_size;
    logic      r_eol,    n_eol;
    logic      r_out_valid, n_out_valid;
    t_value    r_out_value;
    logic      r_out_glast;
    logic      r_out_llast;
    t_cell_ctl w_ctl;
    t_value    w_top;
    logic      w_in_acc;
    t_count    w_count_inc;

    assign i_in.ready  = (r_state == ST_FILL);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_count_inc = r_count + t_count'(1);

    // Push on input, pop when the output register can take a value
    always_comb begin
        w_ctl.push = w_in_acc;
        w_ctl.pop  = (r_state == ST_DRAIN) && (!r_out_valid || o_out.ready);
    end

    // Clamp the written group size into the legal range
    always_comb begin
        n_size = r_size;
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_size = t_count'(1);
            end else if (int'(i_cfg_data) > MAX_GROUP) begin
                n_size = t_count'(MAX_GROUP);
            end else begin
                n_size = t_count'(i_cfg_data);
            end
        end
    end

    // Fill and drain sequencing
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_eol   = r_eol;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    n_count = w_count_inc;
                    n_eol   = i_in.end_of_list;
                    if ((w_count_inc >= r_size) || i_in.end_of_list) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_ctl.pop) begin
                    n_count = r_count - t_count'(1);
                    if (r_count == t_count'(1)) begin
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // Output register: load on pop, drop valid when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.pop) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_size      <= t_count'(1);
            r_eol       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_size      <= n_size;
            r_eol       <= n_eol;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload unless a new value is popped
    always_ff @(posedge i_clk) begin
        if (w_ctl.pop) begin
            r_out_value <= w_top;
            r_out_glast <= (r_count == t_count'(1));
            r_out_llast <= (r_count == t_count'(1)) && r_eol;
        end
    end

    grr_stack u_stack (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_push_value (i_in.value),
        .o_top        (w_top)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.value_res  = r_out_value;
    assign o_out.group_last = r_out_glast;
    assign o_out.list_last  = r_out_llast;

endmodule

### tb/sv/group_reverse_reorder_top_tb.sv
// Self-checking testbench for group_reverse_reorder_top: predicts each reversed group
// and compares every output transaction; random gaps and stalls on both channels.
// Depends on grr_pkg, grr_if and the group_reverse_reorder_top RTL.
module group_reverse_reorder_top_tb;
    import grr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_PAD      = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_value value_res;
        logic   group_last;
        logic   list_last;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    grr_in_if  in_ch ();
    grr_out_if out_ch ();

    group_reverse_reorder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state: the group being collected and the active size
    t_value            held_values [MAX_GROUP];
    int                held_count;
    logic [SIZE_W-1:0] model_size;
    t_result           reversed_queue [$];

    int  fail_count;
    int  items_sent;
    int  results_checked;
    int  quiet_cycles;
    int  stall_left;
    bit  send_steady;
    bit  take_steady;
    bit  hold_request;

    always #1 i_clk = ~i_clk;

    function automatic int group_limit();
        if (model_size == '0) return 1;
        if (model_size > MAX_GROUP) return MAX_GROUP;
        return int'(model_size);
    endfunction

    // Buffer one value; on a full group or end of list, queue it reversed
    function automatic void predict_reversal(t_value v, logic eol);
        t_result r;
        int n;
        if (held_count < MAX_GROUP) begin
            held_values[held_count] = v;
            held_count++;
        end
        if (held_count < group_limit() && !eol) return;
        n = held_count;
        for (int i = 0; i < n; i++) begin
            r.value_res  = held_values[n - 1 - i];
            r.group_last = (i == n - 1);
            r.list_last  = (i == n - 1) && eol;
            reversed_queue.insert(reversed_queue.size(), r);
        end
        held_count = 0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then predict
    task automatic send_item(t_value v, logic eol);
        int gap;
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value       <= v;
        in_ch.end_of_list <= eol;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_reversal(v, eol);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (reversed_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_group_size(logic [SIZE_W-1:0] size);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_size = size;
    endtask

    // Send random lists of random length until count transactions went in
    task automatic send_lists(logic [SIZE_W-1:0] size, int count);
        int sent;
        int len;
        int k;
        write_group_size(size);
        k = group_limit();
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 3 * k + 1);
            for (int j = 0; j < len && sent < count; j++) begin
                send_item(pick_value(), j == len - 1);
                sent++;
            end
        end
    endtask

    // Reset size of one: every value is its own group
    task automatic test_reset_size();
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
    endtask

    // Size zero acts as one, an oversized value acts as the maximum
    task automatic test_size_extremes();
        write_group_size('0);
        send_item('1, 1'b0);
        write_group_size('1);
        for (int i = 0; i < MAX_GROUP; i++)
            send_item((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555 + i, 1'b0);
    endtask

    // Lower the size with values buffered; the next value flushes them all
    task automatic test_size_lowered();
        write_group_size(5'd8);
        for (int i = 0; i < 4; i++) send_item(pick_value(), 1'b0);
        write_group_size(5'd2);
        send_item(pick_value(), 1'b0);
    endtask

    task automatic test_random_sizes();
        logic [SIZE_W-1:0] size;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: size = 5'd1;
                1: size = 5'd2;
                2: size = 5'd3;
                3: size = 5'd16;
                4: size = 5'd0;
                5: size = 5'd24;
                6: size = 5'd5;
                default: size = SIZE_W'($urandom_range(1, MAX_GROUP));
            endcase
            send_steady = (p % 4 == 3);
            take_steady = (p % 4 == 3);
            send_lists(size, 30);
        end
        send_steady = 1'b0;
        take_steady = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls
    task automatic test_backpressure();
        write_group_size(5'd4);
        send_steady  = 1'b1;
        hold_request = 1'b1;
        send_lists(5'd4, 25);
        send_steady = 1'b0;
        send_lists(5'd7, 25);
    endtask

    // Receiver: random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (hold_request) begin
            out_ch.ready <= 1'b0;
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
        end else if (!take_steady && $urandom_range(0, 99) < 25) begin
            out_ch.ready <= 1'b0;
            stall_left   = pick_gap(1'b0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (reversed_queue.size() == 0) begin
                $display("%0t: unexpected result value=%0d group_last=%b list_last=%b",
                         $time, out_ch.value_res, out_ch.group_last, out_ch.list_last);
                fail_count++;
            end else begin
                exp_r = reversed_queue.pop_front();
                if (out_ch.value_res !== exp_r.value_res) begin
                    $display("%0t: value_res expected %0d actual %0d",
                             $time, exp_r.value_res, out_ch.value_res);
                    fail_count++;
                end
                if (out_ch.group_last !== exp_r.group_last) begin
                    $display("%0t: group_last expected %b actual %b",
                             $time, exp_r.group_last, out_ch.group_last);
                    fail_count++;
                end
                if (out_ch.list_last !== exp_r.list_last) begin
                    $display("%0t: list_last expected %b actual %b",
                             $time, exp_r.list_last, out_ch.list_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.value       = '0;
        in_ch.end_of_list = 1'b0;
        out_ch.ready      = 1'b0;
        held_count        = 0;
        model_size        = 5'd1;
        fail_count        = 0;
        items_sent        = 0;
        results_checked   = 0;
        quiet_cycles      = 0;
        stall_left        = 0;
        send_steady       = 1'b0;
        take_steady       = 1'b0;
        hold_request      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_size_extremes();
        test_size_lowered();
        test_random_sizes();
        test_backpressure();
        wait_drained();

        $display("Sent %0d values, checked %0d reversed results over group sizes 0 to 31,",
                 items_sent, results_checked);
        $display("with random gaps, stalls, a long receiver hold and a mid-group resize.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
design/grr_pkg.sv
design/grr_if.sv
design/grr_cell.sv
design/grr_stack.sv
design/group_reverse_reorder_top.sv
tb/sv/group_reverse_reorder_top_tb.sv
